### rtl/nkct_pkg.sv
// nkct_pkg: sizes, codes and shared types of the named counter table
// used by nkct_cell and name_keyed_counter_table; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nkct_pkg;

   localparam int NAME_LEN = 32;
   localparam int ENTRIES  = 64;

   // characters kept of each name
   localparam int KEEP = NAME_LEN - 1;

   localparam int KEY_LEN_W = $clog2(KEEP + 1);
   localparam int KEY_IDX_W = (KEEP > 1) ? $clog2(KEEP) : 1;
   localparam int ENT_IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int USED_W    = $clog2(ENTRIES + 1);

   localparam int CHAR_W   = 8;
   localparam int TOTAL_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic OP_CHAR  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CREATED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef logic [KEEP-1:0][CHAR_W-1:0] name_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                 clear;
      logic                 restart;
      logic                 char_en;
      logic                 in_range;
      logic [KEY_IDX_W-1:0] pos;
      logic [CHAR_W-1:0]    ch;
      logic [KEY_LEN_W-1:0] key_len;
      logic                 append;
      logic                 wr_total;
      logic [TOTAL_W-1:0]   total;
   } cell_ctrl_type;

   // what a cell reports back
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [TOTAL_W-1:0] total;
   } cell_stat_type;

endpackage

`default_nettype wire

### rtl/name_keyed_counter_table.sv
// name_keyed_counter_table: top level, controller, key register and the row of entry cells
// depends on nkct_pkg and nkct_cell
`timescale 1ns / 1ps
`default_nettype none

// A table of up to ENTRIES named 32-bit counters, held in a row of cells, one
// entry per cell. A name arrives one character per beat on the req side, the
// final character marked by req_tlast; only the first NAME_LEN-1 characters
// are kept, and a zero character is an ordinary character. Each cell keeps a
// match flag that is narrowed on every kept character, so when the final beat
// comes in the comparison is already done: S_LOOK gathers the hit, S_UPD
// adds the amount and writes it back (or appends a new entry at the end of the
// row, whose cells mark themselves in use left to right). A character beat
// that is not final leaves the controller in S_IDLE; a final one passes S_LOOK
// and S_UPD, which waits while the rsp side holds an earlier beat. A clear
// beat (req_tuser high) empties the table, drops a partial name and gives no
// rsp beat. Every final character gives exactly one rsp beat: status 0 existing
// entry updated, 1 new entry created, 2 table full (index and total zero,
// nothing stored). The entry index on the rsp side is the table slot modulo 64.

module name_keyed_counter_table
   import nkct_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // name_char[7:0], add_amount[39:8]
   input  wire logic                  req_tuser,  // opcode
   input  wire logic                  req_tlast,  // last_char
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // entry_index[5:0], entry_total[37:6], zero pad
   output logic [STATUS_W-1:0]        rsp_tuser   // status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_UPD
   } state_type;

   state_type            state_ff;
   logic [KEY_LEN_W-1:0] key_len_ff;
   name_type             key_ff;
   logic [USED_W-1:0]    used_ff;
   logic [TOTAL_W-1:0]   amount_ff;
   logic                 found_ff;
   logic                 full_ff;
   logic [ENT_IDX_W-1:0] hit_idx_ff;
   logic [TOTAL_W-1:0]   old_total_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]  rsp_user_ff;

   cell_ctrl_type        ctrl;
   cell_stat_type        stat [ENTRIES];
   logic [ENTRIES-1:0]   wr_sel;
   logic                 req_beat;
   logic                 in_range;
   logic                 rsp_free;
   logic [ENT_IDX_W-1:0] tgt_idx;
   logic [TOTAL_W-1:0]   sum;
   logic                 any_hit;
   logic [ENT_IDX_W-1:0] hit_idx;
   logic [TOTAL_W-1:0]   hit_total;

   wire logic [CHAR_W-1:0]  req_char   = req_tdata[CHAR_W-1:0];
   wire logic [TOTAL_W-1:0] req_amount = req_tdata[CHAR_W+TOTAL_W-1:CHAR_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign in_range   = (key_len_ff < KEY_LEN_W'(KEEP));
   // output register free or being emptied this cycle
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // slot written on update: matched entry, else the next free one
   assign tgt_idx = found_ff ? hit_idx_ff : used_ff[ENT_IDX_W-1:0];
   assign sum     = (found_ff ? old_total_ff : '0) + amount_ff;

   // at most one entry can match, names in the table being distinct
   always_comb begin
      any_hit   = 1'b0;
      hit_idx   = '0;
      hit_total = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (stat[i].hit) begin
            any_hit   = 1'b1;
            hit_idx   = hit_idx | ENT_IDX_W'(i);
            hit_total = hit_total | stat[i].total;
         end
      end
   end

   // broadcast to the cells
   always_comb begin
      ctrl          = '0;
      ctrl.pos      = key_len_ff[KEY_IDX_W-1:0];
      ctrl.ch       = req_char;
      ctrl.in_range = in_range;
      ctrl.key_len  = key_len_ff;
      ctrl.total    = sum;
      if (state_ff == S_IDLE && req_beat) begin
         if (req_tuser == OP_CLEAR) begin
            ctrl.clear = 1'b1;
         end else begin
            ctrl.char_en = 1'b1;
         end
      end
      if (state_ff == S_UPD && rsp_free) begin
         ctrl.restart  = 1'b1;
         ctrl.wr_total = found_ff | ~full_ff;
         ctrl.append   = ~found_ff & ~full_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         wr_sel[i] = (tgt_idx == ENT_IDX_W'(i));
      end
   end

   // the row of cells; each looks at its left neighbour's in-use flag
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic prev_valid;
      if (g == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = stat[g-1].valid;
      end

      nkct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key_name   (key_ff),
         .prev_valid (prev_valid),
         .wr_sel     (wr_sel[g]),
         .stat       (stat[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_len_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drained beat, unless a new one is loaded below
         if (rsp_valid_ff && rsp_tready && !(state_ff == S_UPD && rsp_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  if (req_tuser == OP_CLEAR) begin
                     key_len_ff <= '0;
                     used_ff    <= '0;
                  end else begin
                     if (in_range) begin
                        key_ff[key_len_ff[KEY_IDX_W-1:0]] <= req_char;
                        key_len_ff <= key_len_ff + KEY_LEN_W'(1);
                     end
                     if (req_tlast) begin
                        amount_ff <= req_amount;
                        state_ff  <= S_LOOK;
                     end
                  end
               end
            end
            S_LOOK: begin
               found_ff     <= any_hit;
               hit_idx_ff   <= hit_idx;
               old_total_ff <= hit_total;
               full_ff      <= (used_ff == USED_W'(ENTRIES));
               state_ff     <= S_UPD;
            end
            S_UPD: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  key_len_ff   <= '0;
                  state_ff     <= S_IDLE;
                  if (found_ff) begin
                     rsp_user_ff <= ST_UPDATED;
                     rsp_data_ff <= {(RSP_DATA_W - INDEX_W - TOTAL_W)'(0), sum,
                                     INDEX_W'(tgt_idx)};
                  end else if (!full_ff) begin
                     used_ff     <= used_ff + USED_W'(1);
                     rsp_user_ff <= ST_CREATED;
                     rsp_data_ff <= {(RSP_DATA_W - INDEX_W - TOTAL_W)'(0), sum,
                                     INDEX_W'(tgt_idx)};
                  end else begin
                     rsp_user_ff <= ST_FULL;
                     rsp_data_ff <= '0;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### rtl/nkct_cell.sv
// nkct_cell: one table entry with its stored name, length, total and running match flag
// depends on nkct_pkg
`timescale 1ns / 1ps
`default_nettype none

module nkct_cell
   import nkct_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire name_type      key_name,
   input  wire logic          prev_valid,
   input  wire logic          wr_sel,
   output cell_stat_type      stat
);

   logic                 valid_ff, valid_in;
   logic                 match_ff, match_in;
   name_type             name_ff;
   logic [KEY_LEN_W-1:0] len_ff;
   logic [TOTAL_W-1:0]   total_ff;
   logic                 load;

   // first free cell is the one whose left neighbour is in use
   assign load = ctrl.append & prev_valid & ~valid_ff;

   always_comb begin
      match_in = match_ff;
      if (ctrl.clear || ctrl.restart) begin
         match_in = 1'b1;
      end else if (ctrl.char_en && ctrl.in_range) begin
         match_in = match_ff & (name_ff[ctrl.pos] == ctrl.ch);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         name_ff <= key_name;
         len_ff  <= ctrl.key_len;
      end
      if (wr_sel && ctrl.wr_total) begin
         total_ff <= ctrl.total;
      end
   end

   assign stat.valid = valid_ff;
   assign stat.hit   = valid_ff & match_ff & (len_ff == ctrl.key_len);
   assign stat.total = total_ff;

endmodule

`default_nettype wire

### test/tb_top.sv
// tb_top: self-checking bench for name_keyed_counter_table, names streamed one beat per character
// depends on nkct_pkg and the rtl top level; predicts every response beat in-line
`timescale 1ns / 1ps

module tb_top;
   import nkct_pkg::*;

   // longest name the stimulus builds, past the kept length so truncation is exercised
   localparam int NAME_MAX = KEEP + 14;
   localparam int POOL_MAX = 96;
   localparam int RANDOM_BEATS = 1450;
   localparam int SETTLE_CYCLES = 20;

   // one request beat as the bench sees it; hold keeps it back until all responses are in
   typedef struct packed {
      logic                opcode;
      logic [CHAR_W-1:0]   ch;
      logic                last;
      logic [TOTAL_W-1:0]  amount;
      logic                hold;
   } req_beat_type;

   // one response beat
   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [TOTAL_W-1:0]  total;
      logic [STATUS_W-1:0] status;
   } report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // name_char[7:0], add_amount[39:8]
   logic                  req_tuser = 1'b0; // opcode
   logic                  req_tlast = 1'b0; // last_char
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // entry_index[5:0], entry_total[37:6], zero pad
   logic [STATUS_W-1:0]   rsp_tuser;        // status

   name_keyed_counter_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // reset at the start, released once
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // generous ceiling on the whole run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------
   // predicted table: key being assembled and the stored entries
   // ------------------------------------------------------------------
   logic [CHAR_W-1:0]  key_buf [KEEP];
   int                 key_len = 0;
   logic [CHAR_W-1:0]  entry_chars [ENTRIES][KEEP];
   int                 entry_len [ENTRIES];
   logic [TOTAL_W-1:0] entry_sum [ENTRIES];
   int                 used_cnt = 0;

   report_type         pending_reports [$];
   req_beat_type       beat_q [$];
   req_beat_type       beat_cur;
   report_type         due_report;
   int                 pushed = 0;
   int                 accepted = 0;
   int                 errors = 0;

   // apply one accepted beat to the predicted table; returns 1 when a response is owed
   function automatic bit lookup_and_add(input req_beat_type b, output report_type r);
      int  slot;
      bit  hit;
      bit  same;
      r = '0;
      if (b.opcode == OP_CLEAR) begin
         used_cnt = 0;
         key_len  = 0;
         return 1'b0;
      end
      // characters past the kept length are dropped
      if (key_len < KEEP) begin
         key_buf[key_len] = b.ch;
         key_len++;
      end
      if (!b.last) return 1'b0;

      // exact match on length and on every kept character, lowest slot wins
      hit  = 1'b0;
      slot = 0;
      for (int s = 0; s < used_cnt; s++) begin
         if (!hit && entry_len[s] == key_len) begin
            same = 1'b1;
            for (int i = 0; i < key_len; i++)
               if (entry_chars[s][i] != key_buf[i]) same = 1'b0;
            if (same) begin
               hit  = 1'b1;
               slot = s;
            end
         end
      end

      if (hit) begin
         r.status = ST_UPDATED;
      end else if (used_cnt < ENTRIES) begin
         slot = used_cnt;
         for (int i = 0; i < key_len; i++) entry_chars[slot][i] = key_buf[i];
         entry_len[slot] = key_len;
         entry_sum[slot] = '0;
         used_cnt++;
         r.status = ST_CREATED;
      end else begin
         // table full: nothing stored, name dropped, index and total zero
         key_len  = 0;
         r.status = ST_FULL;
         return 1'b1;
      end
      entry_sum[slot] = entry_sum[slot] + b.amount;
      key_len = 0;
      r.index = slot[INDEX_W-1:0];
      r.total = entry_sum[slot];
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // driver: bursts of beats with random gaps, held beats wait for a drain
   // ------------------------------------------------------------------
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted++;
            if (lookup_and_add(beat_cur, due_report)) pending_reports.push_back(due_report);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (beat_q.size() > 0 &&
                         !(beat_q[0].hold && pending_reports.size() != 0)) begin
               beat_cur = beat_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {beat_cur.amount, beat_cur.ch};
               req_tuser  <= beat_cur.opcode;
               req_tlast  <= beat_cur.last;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  // a quarter of bursts run straight on with no gap
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: stall pattern switches between four random modes
   // ------------------------------------------------------------------
   int rx_mode = 0;
   int rx_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(30, 300);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= ((rx_left % 6) < 3);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // monitor: every response beat against the oldest prediction
   // ------------------------------------------------------------------
   report_type got_report;
   report_type want_report;

   task automatic note_failure(input string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_report.index  = rsp_tdata[INDEX_W-1:0];
         got_report.total  = rsp_tdata[INDEX_W +: TOTAL_W];
         got_report.status = rsp_tuser;
         if (pending_reports.size() == 0) begin
            note_failure($sformatf("unexpected beat index %0d total %h status %0d",
                                   got_report.index, got_report.total, got_report.status));
         end else begin
            want_report = pending_reports.pop_front();
            if (got_report !== want_report)
               note_failure($sformatf(
                  "index %0d/%0d total %h/%h status %0d/%0d (expected/actual)",
                  want_report.index, got_report.index, want_report.total,
                  got_report.total, want_report.status, got_report.status));
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus: pools of names, reused for hits, varied for near misses
   // ------------------------------------------------------------------
   logic [CHAR_W-1:0] pool_chars [POOL_MAX][NAME_MAX];
   int                pool_len [POOL_MAX];
   int                pool_n = 0;

   task automatic push_beat(input logic op, input logic [CHAR_W-1:0] ch, input logic last,
                            input logic [TOTAL_W-1:0] amount, input logic hold);
      req_beat_type b;
      b.opcode = op;
      b.ch     = ch;
      b.last   = last;
      b.amount = amount;
      b.hold   = hold;
      beat_q.push_back(b);
      pushed++;
   endtask

   // extremes now and then, otherwise anything
   function automatic logic [TOTAL_W-1:0] rand_amount();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return TOTAL_W'($urandom);
      endcase
   endfunction

   // mostly short names, some around and beyond the kept length
   function automatic int rand_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(KEEP - 2, NAME_MAX);
      return $urandom_range(1, 6);
   endfunction

   function automatic int add_pool_name(input int len);
      for (int i = 0; i < len; i++) pool_chars[pool_n][i] = CHAR_W'($urandom);
      pool_len[pool_n] = len;
      pool_n++;
      return pool_n - 1;
   endfunction

   // characters past the kept length get fresh values: still the same key
   task automatic send_name(input int p, input bit hold_first);
      int                n;
      logic [CHAR_W-1:0] c;
      n = pool_len[p];
      for (int i = 0; i < n; i++) begin
         c = (i < KEEP) ? pool_chars[p][i] : CHAR_W'($urandom);
         push_beat(OP_CHAR, c, i == n - 1, (i == n - 1) ? rand_amount() : TOTAL_W'($urandom),
                   hold_first && i == 0);
      end
   endtask

   int  directed_n;
   int  kind;
   int  picks;
   int  p;
   int  q;
   int  r;
   bit  first_session;

   initial begin
      // clear with every other field set, gives nothing back
      push_beat(OP_CLEAR, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
      // zero character is an ordinary one-character name
      push_beat(OP_CHAR, 8'h00, 1'b1, 32'h7FFF_FFFF, 1'b0);
      // hit, wraps over to the most negative total
      push_beat(OP_CHAR, 8'h00, 1'b1, 32'h0000_0001, 1'b0);
      push_beat(OP_CHAR, 8'hFF, 1'b1, 32'h8000_0000, 1'b0);
      // same characters in either order are different names
      push_beat(OP_CHAR, 8'h00, 1'b0, 32'h1234_5678, 1'b0);
      push_beat(OP_CHAR, 8'hFF, 1'b1, 32'h0000_0000, 1'b0);
      push_beat(OP_CHAR, 8'hFF, 1'b0, 32'h0000_0000, 1'b0);
      push_beat(OP_CHAR, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0);
      push_beat(OP_CHAR, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0);
      // partial name dropped by a clear
      push_beat(OP_CHAR, 8'h41, 1'b0, 32'hAAAA_5555, 1'b0);
      push_beat(OP_CHAR, 8'h42, 1'b0, 32'h5555_AAAA, 1'b0);
      push_beat(OP_CLEAR, 8'h00, 1'b0, 32'h0000_0000, 1'b0);
      // table empty again, held back until everything has drained
      push_beat(OP_CHAR, 8'h42, 1'b1, 32'h7FFF_FFFF, 1'b1);
      push_beat(OP_CHAR, 8'h42, 1'b1, 32'h7FFF_FFFF, 1'b0);
      push_beat(OP_CHAR, 8'h41, 1'b0, 32'h0000_0000, 1'b0);
      push_beat(OP_CHAR, 8'h42, 1'b1, 32'h0000_0000, 1'b0);
      directed_n = pushed;

      // sessions, each opened by a clear; the first one fills the table
      first_session = 1'b1;
      while (pushed < directed_n + RANDOM_BEATS) begin
         kind = first_session ? 5 : $urandom_range(0, 5);
         push_beat(OP_CLEAR, CHAR_W'($urandom), 1'($urandom), TOTAL_W'($urandom),
                   first_session || $urandom_range(0, 2) == 0);
         first_session = 1'b0;
         pool_n = 0;
         if (kind == 5) begin
            // more freshly drawn names than slots, then revisit old and new ones
            for (int k = 0; k < ENTRIES + 16; k++) begin
               p = add_pool_name($urandom_range(2, 4));
               send_name(p, 1'b0);
            end
            repeat (30) send_name($urandom_range(0, pool_n - 1), 1'b0);
         end else begin
            q = (kind < 3) ? $urandom_range(1, 5) : $urandom_range(8, 30);
            repeat (q) p = add_pool_name(rand_len());
            picks = $urandom_range(25, 60);
            // stop once the beat budget is spent
            for (int k = 0; k < picks && pushed < directed_n + RANDOM_BEATS; k++) begin
               r = $urandom_range(0, 19);
               if (r < 15) begin
                  send_name($urandom_range(0, pool_n - 1), 1'b0);
               end else if (r < 17 && pool_n < POOL_MAX) begin
                  // near miss: one shorter, one longer or one character changed
                  p = $urandom_range(0, pool_n - 1);
                  q = pool_n;
                  pool_chars[q] = pool_chars[p];
                  pool_len[q] = pool_len[p];
                  case ($urandom_range(0, 2))
                     0: if (pool_len[q] > 1) pool_len[q]--;
                     1: if (pool_len[q] < NAME_MAX) begin
                        pool_chars[q][pool_len[q]] = CHAR_W'($urandom);
                        pool_len[q]++;
                     end
                     default: pool_chars[q][$urandom_range(0, pool_len[q] - 1)] =
                                 CHAR_W'($urandom);
                  endcase
                  pool_n++;
                  send_name(q, 1'b0);
               end else if (r < 19) begin
                  // broken name: a few characters, then a clear
                  repeat ($urandom_range(1, 3))
                     push_beat(OP_CHAR, CHAR_W'($urandom), 1'b0, TOTAL_W'($urandom), 1'b0);
                  push_beat(OP_CLEAR, CHAR_W'($urandom), 1'($urandom), TOTAL_W'($urandom),
                            1'b0);
               end else begin
                  push_beat(OP_CLEAR, CHAR_W'($urandom), 1'($urandom), TOTAL_W'($urandom),
                            1'b0);
               end
            end
         end
      end

      // wait for every beat to go in and every response to come back
      while (accepted < pushed || pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
